// ===== sv/hst_pkg.sv =====
// ----------------------------------------------------------------------------
// hst_pkg: shared types and constants of the hall sector tracker
// Operation codes, register indexes, motion codes and the Hall code to
// sector map.
// ----------------------------------------------------------------------------
package hst_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 32;
   localparam int TIMER_WIDTH_DEFAULT = 16;

   localparam int CODE_WIDTH     = 3;
   localparam int SECTOR_WIDTH   = 3;
   localparam int HOLD_WIDTH     = 8;
   localparam int TIMEOUT_WIDTH  = 16;
   localparam int CSR_DATA_WIDTH = 16;
   localparam int CSR_ADDR_WIDTH = 1;

   typedef logic [CODE_WIDTH-1:0]   code_type;
   typedef logic [SECTOR_WIDTH-1:0] sector_type;
   typedef logic signed [1:0]       motion_type;

   typedef enum logic [1:0] {
      OP_TICK      = 2'd0,
      OP_DIRECT    = 2'd1,
      OP_REFERENCE = 2'd2,
      OP_CLEAR     = 2'd3
   } opcode_type;

   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      CSR_HOLD_TICKS   = 1'b0,
      CSR_IDLE_TIMEOUT = 1'b1
   } csr_index_type;

   localparam motion_type MOTION_STOP = 2'sb00;
   localparam motion_type MOTION_FWD  = 2'sb01;
   localparam motion_type MOTION_BWD  = 2'sb11;

   localparam code_type    CODE_RESET    = 3'd1;
   localparam sector_type  SECTOR_NONE   = 3'd0;
   localparam sector_type  SECTOR_FIRST  = 3'd1;
   localparam sector_type  SECTOR_LAST   = 3'd6;
   localparam logic [HOLD_WIDTH-1:0]    HOLD_RESET    = 8'd2;
   localparam logic [TIMEOUT_WIDTH-1:0] TIMEOUT_RESET = 16'd800;

   // sectors 1..6 follow codes 1,5,4,6,2,3; codes 0 and 7 are invalid
   function automatic sector_type sector_of(input code_type code);
      sector_type s;
      case (code)
         3'd1:    s = 3'd1;
         3'd5:    s = 3'd2;
         3'd4:    s = 3'd3;
         3'd6:    s = 3'd4;
         3'd2:    s = 3'd5;
         3'd3:    s = 3'd6;
         default: s = SECTOR_NONE;
      endcase
      return s;
   endfunction

endpackage

// ===== sv/hall_sector_tracker.sv =====
// ----------------------------------------------------------------------------
// hall_sector_tracker: Hall sensor sector, direction and position tracker
// Filters pin samples, maps codes to sectors, counts steps and faults.
// ----------------------------------------------------------------------------
// The sector map, the step compare and the saturating counter updates sit
// between the state registers and the response register, so a beat can be
// accepted on every clock while the response register drains. A response beat
// appears in the cycle after its request beat is accepted.
// Opcode tick filters the pin sample (it must hold for hold_ticks ticks) and
// ages the direction, which clears after idle_timeout ticks without a move;
// opcode direct takes the code unfiltered; reference zeroes position and
// direction and takes the code without a step; clear zeroes position, faults
// and direction. Position and fault count saturate. Registers must be written
// through the csr port only while the block is idle; this is not enforced.
module hall_sector_tracker #(
   parameter int COUNT_WIDTH = hst_pkg::COUNT_WIDTH_DEFAULT,
   parameter int TIMER_WIDTH = hst_pkg::TIMER_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [1:0]                            req_opcode,
   input  logic [hst_pkg::CODE_WIDTH-1:0]        req_hall_code,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [hst_pkg::CODE_WIDTH-1:0]        rsp_hall_now,
   output logic [hst_pkg::SECTOR_WIDTH-1:0]      rsp_sector,
   output logic signed [1:0]                     rsp_motion,
   output logic signed [COUNT_WIDTH-1:0]         rsp_position,
   output logic [COUNT_WIDTH-1:0]                rsp_fault_count,
   output logic                                  rsp_changed,
   // register write channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [hst_pkg::CSR_ADDR_WIDTH-1:0]    csr_index,
   input  logic [hst_pkg::CSR_DATA_WIDTH-1:0]    csr_data
);

   localparam int CMP_WIDTH = (TIMER_WIDTH > hst_pkg::TIMEOUT_WIDTH) ?
                              TIMER_WIDTH : hst_pkg::TIMEOUT_WIDTH;
   localparam logic signed [COUNT_WIDTH-1:0] POS_MAX =
      {1'b0, {(COUNT_WIDTH-1){1'b1}}};
   localparam logic signed [COUNT_WIDTH-1:0] POS_MIN =
      {1'b1, {(COUNT_WIDTH-1){1'b0}}};

   // configuration
   logic [hst_pkg::HOLD_WIDTH-1:0]    hold_ticks_ff;
   logic [hst_pkg::TIMEOUT_WIDTH-1:0] idle_timeout_ff;

   // tracker state
   hst_pkg::code_type                 accepted_ff,  accepted_in;
   hst_pkg::sector_type               sector_ff,    sector_in;
   hst_pkg::motion_type               direction_ff, direction_in;
   logic signed [COUNT_WIDTH-1:0]     position_ff,  position_in;
   logic [COUNT_WIDTH-1:0]            fault_ff,     fault_in;
   hst_pkg::code_type                 pending_ff,   pending_in;
   logic [hst_pkg::HOLD_WIDTH-1:0]    stable_ff,    stable_in;
   logic [TIMER_WIDTH-1:0]            idle_ff,      idle_in;

   // response register
   logic                              rsp_valid_ff;
   logic                              changed_ff,   changed_in;

   logic                              req_fire;
   logic                              do_accept;
   logic                              is_reference;
   hst_pkg::opcode_type               op;
   hst_pkg::sector_type               next_sector;
   logic                              step_fwd;
   logic                              step_bwd;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign op        = hst_pkg::opcode_type'(req_opcode);

   assign next_sector = hst_pkg::sector_of(req_hall_code);

   // one sector forward or back, with wrap between sector 6 and sector 1
   assign step_fwd = (next_sector == sector_ff + 3'd1) ||
                     (sector_ff == hst_pkg::SECTOR_LAST &&
                      next_sector == hst_pkg::SECTOR_FIRST);
   assign step_bwd = (next_sector == sector_ff - 3'd1) ||
                     (sector_ff == hst_pkg::SECTOR_FIRST &&
                      next_sector == hst_pkg::SECTOR_LAST);

   always_comb begin
      accepted_in  = accepted_ff;
      sector_in    = sector_ff;
      direction_in = direction_ff;
      position_in  = position_ff;
      fault_in     = fault_ff;
      pending_in   = pending_ff;
      stable_in    = stable_ff;
      idle_in      = idle_ff;
      do_accept    = 1'b0;
      is_reference = 1'b0;

      case (op)
         hst_pkg::OP_TICK: begin
            if (idle_ff != '1) begin
               idle_in = idle_ff + 1'b1;
            end
            if (req_hall_code != pending_ff) begin
               pending_in = req_hall_code;
               stable_in  = '0;
            end else if (stable_ff != '1) begin
               stable_in = stable_ff + 1'b1;
            end
            do_accept = (stable_in >= hold_ticks_ff) && (req_hall_code != accepted_ff);
         end
         hst_pkg::OP_DIRECT: begin
            do_accept = (req_hall_code != accepted_ff);
         end
         hst_pkg::OP_REFERENCE: begin
            position_in  = '0;
            direction_in = hst_pkg::MOTION_STOP;
            do_accept    = 1'b1;
            is_reference = 1'b1;
         end
         hst_pkg::OP_CLEAR: begin
            position_in  = '0;
            fault_in     = '0;
            direction_in = hst_pkg::MOTION_STOP;
         end
         default: begin
            do_accept = 1'b0;
         end
      endcase

      if (do_accept) begin
         direction_in = hst_pkg::MOTION_STOP;
         if (next_sector == hst_pkg::SECTOR_NONE) begin
            if (fault_ff != '1) begin
               fault_in = fault_ff + 1'b1;
            end
         end else if (!is_reference && sector_ff != hst_pkg::SECTOR_NONE) begin
            if (step_fwd) begin
               direction_in = hst_pkg::MOTION_FWD;
               if (position_ff != POS_MAX) begin
                  position_in = position_ff + 1'b1;
               end
            end else if (step_bwd) begin
               direction_in = hst_pkg::MOTION_BWD;
               if (position_ff != POS_MIN) begin
                  position_in = position_ff - 1'b1;
               end
            end else if (next_sector != sector_ff) begin
               if (fault_ff != '1) begin
                  fault_in = fault_ff + 1'b1;
               end
            end
         end
         accepted_in = req_hall_code;
         sector_in   = next_sector;
         idle_in     = '0;
      end

      // direction ages out on ticks only
      if (op == hst_pkg::OP_TICK && direction_in != hst_pkg::MOTION_STOP &&
          CMP_WIDTH'(idle_in) >= CMP_WIDTH'(idle_timeout_ff)) begin
         direction_in = hst_pkg::MOTION_STOP;
      end

      changed_in = (accepted_in != accepted_ff) || (sector_in != sector_ff) ||
                   (direction_in != direction_ff) || (position_in != position_ff) ||
                   (fault_in != fault_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ticks_ff   <= hst_pkg::HOLD_RESET;
         idle_timeout_ff <= hst_pkg::TIMEOUT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (hst_pkg::csr_index_type'(csr_index))
            hst_pkg::CSR_HOLD_TICKS: begin
               hold_ticks_ff <= csr_data[hst_pkg::HOLD_WIDTH-1:0];
            end
            hst_pkg::CSR_IDLE_TIMEOUT: begin
               idle_timeout_ff <= csr_data[hst_pkg::TIMEOUT_WIDTH-1:0];
            end
            default: begin
               hold_ticks_ff <= hold_ticks_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accepted_ff  <= hst_pkg::CODE_RESET;
         sector_ff    <= hst_pkg::SECTOR_FIRST;
         direction_ff <= hst_pkg::MOTION_STOP;
         position_ff  <= '0;
         fault_ff     <= '0;
         pending_ff   <= hst_pkg::CODE_RESET;
         stable_ff    <= '0;
         idle_ff      <= '0;
      end else if (req_fire) begin
         accepted_ff  <= accepted_in;
         sector_ff    <= sector_in;
         direction_ff <= direction_in;
         position_ff  <= position_in;
         fault_ff     <= fault_in;
         pending_ff   <= pending_in;
         stable_ff    <= stable_in;
         idle_ff      <= idle_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // response beat reads the state registers, loaded on the same edge
   always_ff @(posedge clock) begin
      if (req_fire) begin
         changed_ff <= changed_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hall_now    = accepted_ff;
   assign rsp_sector      = sector_ff;
   assign rsp_motion      = direction_ff;
   assign rsp_position    = position_ff;
   assign rsp_fault_count = fault_ff;
   assign rsp_changed     = changed_ff;

endmodule

// ===== sim/hst_reading_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hst_reading_checker: response checker for the hall sector tracker
// Watches the request, response and register channels, keeps its own copy of
// the tracker state and configuration, predicts one reading per request beat
// and compares every response beat, field by field, with the oldest reading.
// ----------------------------------------------------------------------------
module hst_reading_checker
   import hst_pkg::*;
(
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_valid,
   input  logic                                          req_ready,
   input  logic [1:0]                                    req_opcode,
   input  code_type                                      req_hall_code,
   input  logic                                          rsp_valid,
   input  logic                                          rsp_ready,
   input  code_type                                      rsp_hall_now,
   input  sector_type                                    rsp_sector,
   input  motion_type                                    rsp_motion,
   input  logic signed [hst_pkg::COUNT_WIDTH_DEFAULT-1:0] rsp_position,
   input  logic [hst_pkg::COUNT_WIDTH_DEFAULT-1:0]       rsp_fault_count,
   input  logic                                          rsp_changed,
   input  logic                                          csr_valid,
   input  logic                                          csr_ready,
   input  logic [CSR_ADDR_WIDTH-1:0]                     csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]                     csr_data,
   output int                                            mismatches,
   output int                                            readings_waiting
);

   localparam int CW = COUNT_WIDTH_DEFAULT;
   localparam int TW = TIMER_WIDTH_DEFAULT;
   localparam logic signed [CW-1:0] POS_TOP    = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] POS_BOTTOM = {1'b1, {(CW-1){1'b0}}};
   localparam code_type SECTOR_CODES [6] = '{3'd1, 3'd5, 3'd4, 3'd6, 3'd2, 3'd3};

   typedef struct {
      code_type               hall_now;
      sector_type             sector;
      motion_type             motion;
      logic signed [CW-1:0]   position;
      logic [CW-1:0]          fault_count;
      logic                   changed;
   } hall_reading_type;

   hall_reading_type due_readings[$];
   int fail_total = 0;
   int due_count  = 0;

   // tracker copy
   code_type               acc_code;
   sector_type             cur_sector;
   motion_type             dir;
   logic signed [CW-1:0]   pos;
   logic [CW-1:0]          faults;
   code_type               pend_code;
   logic [HOLD_WIDTH-1:0]  stable_cnt;
   logic [TW-1:0]          idle_cnt;
   logic [HOLD_WIDTH-1:0]  cfg_hold;
   logic [TIMEOUT_WIDTH-1:0] cfg_timeout;

   assign mismatches       = fail_total;
   assign readings_waiting = due_count;

   function automatic sector_type sector_for(code_type c);
      for (int i = 0; i < 6; i++)
         if (SECTOR_CODES[i] == c) return sector_type'(i + 1);
      return SECTOR_NONE;
   endfunction

   function automatic void reset_tracker();
      acc_code    = CODE_RESET;
      cur_sector  = SECTOR_FIRST;
      dir         = MOTION_STOP;
      pos         = '0;
      faults      = '0;
      pend_code   = CODE_RESET;
      stable_cnt  = '0;
      idle_cnt    = '0;
      cfg_hold    = HOLD_RESET;
      cfg_timeout = TIMEOUT_RESET;
   endfunction

   function automatic void take_code(code_type c, bit as_reference);
      sector_type nxt;
      int         delta;
      nxt = sector_for(c);
      if (!as_reference && c == acc_code) return;
      dir = MOTION_STOP;
      if (nxt == SECTOR_NONE) begin
         if (faults != '1) faults++;
      end else if (!as_reference && cur_sector != SECTOR_NONE) begin
         delta = (int'(nxt) + 6 - int'(cur_sector)) % 6;
         if (delta == 1) dir = MOTION_FWD;
         else if (delta == 5) dir = MOTION_BWD;
         else if (delta != 0 && faults != '1) faults++;
         if (dir == MOTION_FWD && pos != POS_TOP) pos++;
         if (dir == MOTION_BWD && pos != POS_BOTTOM) pos--;
      end
      acc_code   = c;
      cur_sector = nxt;
      idle_cnt   = '0;
   endfunction

   function automatic hall_reading_type next_reading(opcode_type op, code_type c);
      hall_reading_type r;
      logic [3+3+2+2*CW-1:0] prior;
      prior = {acc_code, cur_sector, dir, pos, faults};
      case (op)
         OP_TICK: begin
            if (idle_cnt != '1) idle_cnt++;
            if (c != pend_code) begin
               pend_code  = c;
               stable_cnt = '0;
            end else if (stable_cnt != '1) begin
               stable_cnt++;
            end
            if (stable_cnt >= cfg_hold && c != acc_code) take_code(c, 1'b0);
            if (dir != MOTION_STOP && idle_cnt >= cfg_timeout) dir = MOTION_STOP;
         end
         OP_DIRECT: take_code(c, 1'b0);
         OP_REFERENCE: begin
            pos = '0;
            dir = MOTION_STOP;
            take_code(c, 1'b1);
         end
         default: begin
            pos    = '0;
            faults = '0;
            dir    = MOTION_STOP;
         end
      endcase
      r.hall_now    = acc_code;
      r.sector      = cur_sector;
      r.motion      = dir;
      r.position    = pos;
      r.fault_count = faults;
      r.changed     = (prior != {acc_code, cur_sector, dir, pos, faults});
      return r;
   endfunction

   task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
         fail_total++;
      end
   endtask

   always @(posedge clock) begin : watch
      hall_reading_type want;
      if (reset) begin
         reset_tracker();
         due_readings.delete();
      end else begin
         // response first: it always belongs to an earlier request beat
         if (rsp_valid && rsp_ready) begin
            if (due_readings.size() == 0) begin
               $display("%0t: response beat with no reading pending, actual hall %h",
                        $time, rsp_hall_now);
               fail_total++;
            end else begin
               want = due_readings.pop_front();
               check_field("hall_now",    64'(want.hall_now),    64'(rsp_hall_now));
               check_field("sector",      64'(want.sector),      64'(rsp_sector));
               check_field("motion",      64'(want.motion),      64'(rsp_motion));
               check_field("position",    64'(want.position),    64'(rsp_position));
               check_field("fault_count", 64'(want.fault_count), 64'(rsp_fault_count));
               check_field("changed",     64'(want.changed),     64'(rsp_changed));
            end
         end
         if (req_valid && req_ready)
            due_readings.push_back(next_reading(opcode_type'(req_opcode), req_hall_code));
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_HOLD_TICKS) cfg_hold = csr_data[HOLD_WIDTH-1:0];
            else cfg_timeout = csr_data[TIMEOUT_WIDTH-1:0];
         end
      end
      due_count = due_readings.size();
   end

endmodule

// ===== sim/tb_hall_sector_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hall_sector_tracker: regression bench for the hall sector tracker
// Drives directed and random request beats under several register settings
// and idle patterns; the reading checker predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_hall_sector_tracker;
   import hst_pkg::*;

   localparam int CW = COUNT_WIDTH_DEFAULT;
   localparam code_type WALK_CODES [6] = '{3'd1, 3'd5, 3'd4, 3'd6, 3'd2, 3'd3};

   logic                        clock         = 1'b0;
   logic                        reset         = 1'b1;
   logic                        req_valid     = 1'b0;
   logic                        req_ready;
   logic [1:0]                  req_opcode    = OP_TICK;
   code_type                    req_hall_code = CODE_RESET;
   logic                        rsp_valid;
   logic                        rsp_ready     = 1'b0;
   code_type                    rsp_hall_now;
   sector_type                  rsp_sector;
   motion_type                  rsp_motion;
   logic signed [CW-1:0]        rsp_position;
   logic [CW-1:0]               rsp_fault_count;
   logic                        rsp_changed;
   logic                        csr_valid     = 1'b0;
   logic                        csr_ready;
   logic [CSR_ADDR_WIDTH-1:0]   csr_index     = CSR_HOLD_TICKS;
   logic [CSR_DATA_WIDTH-1:0]   csr_data      = '0;

   int  send_idle_pct = 15;
   int  rx_idle_pct   = 56;
   logic rx_hold      = 1'b0;
   bit  stall_armed   = 1'b0;
   int  walk_index    = 0;
   int  mismatches;
   int  readings_waiting;

   hall_sector_tracker dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_hall_code   (req_hall_code),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_hall_now    (rsp_hall_now),
      .rsp_sector      (rsp_sector),
      .rsp_motion      (rsp_motion),
      .rsp_position    (rsp_position),
      .rsp_fault_count (rsp_fault_count),
      .rsp_changed     (rsp_changed),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   hst_reading_checker reading_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_hall_code    (req_hall_code),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hall_now     (rsp_hall_now),
      .rsp_sector       (rsp_sector),
      .rsp_motion       (rsp_motion),
      .rsp_position     (rsp_position),
      .rsp_fault_count  (rsp_fault_count),
      .rsp_changed      (rsp_changed),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .mismatches       (mismatches),
      .readings_waiting (readings_waiting)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // long receiver hold-off so the block backs up into the request channel
   initial begin
      wait (stall_armed);
      @(posedge clock);
      rx_hold <= 1'b1;
      repeat (300) @(posedge clock);
      rx_hold <= 1'b0;
   end

   initial begin
      #4_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // valid stays high between back-to-back beats, it only drops on a gap
   task automatic send_beat(opcode_type op, code_type code);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_hall_code <= code;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [CSR_DATA_WIDTH-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic program_tracker(logic [HOLD_WIDTH-1:0] hold,
                                  logic [TIMEOUT_WIDTH-1:0] timeout);
      write_register(CSR_HOLD_TICKS, {{(CSR_DATA_WIDTH-HOLD_WIDTH){1'b0}}, hold});
      write_register(CSR_IDLE_TIMEOUT, timeout);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (readings_waiting != 0);
      repeat (4) @(posedge clock);
   endtask

   // mostly legal sector walks held for a random run, the rest noise
   task automatic send_random(int count, int run_lo, int run_hi);
      int         done;
      int         pick;
      int         run;
      opcode_type op;
      code_type   noise;
      done = 0;
      while (done < count) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            case ($urandom_range(3))
               0:       walk_index = (walk_index + 5) % 6;
               1, 2:    walk_index = (walk_index + 1) % 6;
               default: ;
            endcase
            op  = ($urandom_range(9) == 0) ? OP_DIRECT : OP_TICK;
            run = $urandom_range(run_hi, run_lo);
            repeat (run) begin
               send_beat(op, WALK_CODES[walk_index]);
               done++;
            end
         end else begin
            noise = code_type'($urandom_range(7));
            if (pick < 82) op = OP_TICK;
            else if (pick < 90) op = OP_DIRECT;
            else if (pick < 96) op = OP_REFERENCE;
            else op = OP_CLEAR;
            send_beat(op, noise);
            done++;
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed, reset settings: hold 2, timeout 800
      send_beat(OP_TICK,      3'd1);   // same as accepted, nothing moves
      send_beat(OP_DIRECT,    3'd5);   // forward
      send_beat(OP_DIRECT,    3'd4);   // forward
      send_beat(OP_DIRECT,    3'd5);   // backward
      send_beat(OP_DIRECT,    3'd5);   // repeat ignored
      send_beat(OP_DIRECT,    3'd6);   // two-sector jump
      send_beat(OP_DIRECT,    3'd0);   // invalid code
      send_beat(OP_DIRECT,    3'd2);   // re-reference after invalid
      send_beat(OP_DIRECT,    3'd7);
      send_beat(OP_DIRECT,    3'd7);
      send_beat(OP_REFERENCE, 3'd7);   // reference to invalid still faults
      send_beat(OP_REFERENCE, 3'd3);
      send_beat(OP_REFERENCE, 3'd3);
      send_beat(OP_DIRECT,    3'd1);   // wrap last sector to first
      send_beat(OP_DIRECT,    3'd3);   // wrap back
      send_beat(OP_CLEAR,     3'd7);
      send_beat(OP_TICK,      3'd1);
      send_beat(OP_TICK,      3'd1);
      send_beat(OP_TICK,      3'd1);   // code already accepted, nothing moves
      send_beat(OP_TICK,      3'd1);
      send_beat(OP_TICK,      3'd5);
      send_beat(OP_TICK,      3'd4);   // glitch restarts the hold
      send_beat(OP_CLEAR,     3'd0);
      drain();

      // zero hold, direction cleared every tick
      program_tracker(8'd0, 16'd0);
      send_random(400, 1, 3);
      drain();

      // longest hold, only long stable runs get through the tick filter
      program_tracker(8'd255, 16'hFFFF);
      send_random(700, 240, 300);
      drain();

      send_idle_pct = 56;
      rx_idle_pct   = 15;
      program_tracker(8'd1, 16'd5);
      send_random(500, 1, 4);
      drain();

      send_idle_pct = 0;
      rx_idle_pct   = 0;
      program_tracker(8'd3, 16'd1);
      stall_armed = 1'b1;
      send_random(400, 1, 6);
      drain();

      program_tracker(8'd2, 16'd40);
      send_random(300, 1, 5);
      drain();

      repeat (8) @(negedge clock);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/hst_pkg.sv
sv/hall_sector_tracker.sv
sim/hst_reading_checker.sv
sim/tb_hall_sector_tracker.sv
